[rtl/heightfield_vertex_normal_top_assert.svh]
// Assertion macros for the heightfield vertex normal block.
// Used by heightfield_vertex_normal_top; expects clk and rst_n in scope.
`ifndef HEIGHTFIELD_VERTEX_NORMAL_TOP_ASSERT_SVH
`define HEIGHTFIELD_VERTEX_NORMAL_TOP_ASSERT_SVH

// same-cycle implication
`define HVN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvn assertion failed");

// next-cycle implication
`define HVN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvn assertion failed");

`endif

[rtl/hvn_pkg.sv]
// Types and constants for the heightfield vertex normal block.
// No dependencies.
package hvn_pkg;

  localparam int QW      = 16;  // quotient bits of the normalising divide
  localparam int VEC_W   = 12;  // edge vector component width
  localparam int PROD_W  = 2 * VEC_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SUM_W   = 18;  // four Q2.14 components summed
  localparam int UNIT    = 16384;

  typedef struct packed {
    logic [9:0] grid_x;
    logic [9:0] grid_z;
    logic [7:0] height_up_left;
    logic [7:0] height_mid_left;
    logic [7:0] height_low_left;
    logic [7:0] height_up_right;
    logic [7:0] height_mid_right;
    logic [7:0] height_low_right;
    logic [7:0] height_centre;
    logic [7:0] height_centre_up;
    logic [7:0] height_centre_low;
  } hvn_in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } hvn_out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } hvn_vec_t;

  // helper for an hvn_norm of component width cw; the top level derives LAT from it
  function automatic int hvn_norm_lat(input int cw);
    return cw + 14 + QW;
  endfunction

endpackage

[rtl/hvn_norm.sv]
// Pipelined vector normalise to signed Q2.14: squares, bit-per-stage square root,
// bit-per-stage restoring divide per component. Depends on hvn_pkg.
module hvn_norm import hvn_pkg::*; #(
  parameter int CW = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  output logic                 out_vld,
  output logic signed [15:0]   out_x,
  output logic signed [15:0]   out_y,
  output logic signed [15:0]   out_z
);

  localparam int MW = CW;
  localparam int SW = 2 * MW + 2;
  localparam int RW = SW + 16;
  localparam int K  = RW / 2;
  localparam int DW = K + QW;

  typedef struct packed {
    logic                vld;
    logic                zero;
    logic [2:0]          neg;
    logic [2:0][MW-1:0]  mag;
    logic [RW-1:0]       rad;
    logic [K+1:0]        rem;
    logic [K-1:0]        root;
  } sq_t;

  typedef struct packed {
    logic                vld;
    logic                zero;
    logic [2:0]          neg;
    logic [K-1:0]        dvs;
    logic [2:0][DW-1:0]  rem;
    logic [2:0][QW-1:0]  q;
  } dv_t;

  logic                   in_vld_r, sqr_vld_r, sum_vld_r;
  logic [2:0]             in_neg_r, sqr_neg_r, sum_neg_r;
  logic [2:0][MW-1:0]     in_mag_r, sqr_mag_r, sum_mag_r;
  logic [2:0][MW-1:0]     in_mag_nxt;
  logic [2:0][2*MW-1:0]   sqr_r;
  logic [SW-1:0]          s_r;
  logic signed [CW-1:0]   comp [3];

  sq_t sq_r   [K+1];
  sq_t sq_nxt [K+1];
  dv_t dv_r   [QW+1];
  dv_t dv_nxt [QW+1];

  logic [K+1:0]  rem_sh [K];
  logic [K+1:0]  trial  [K];
  logic [DW-1:0] dshift [QW][3];

  logic              out_vld_r;
  logic signed [15:0] out_c_r [3];
  logic signed [15:0] out_c_nxt [3];
  logic [QW-1:0]      qc [3];

  assign comp[0] = in_x;
  assign comp[1] = in_y;
  assign comp[2] = in_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_mag_nxt[c] = comp[c][CW-1] ? MW'(-comp[c]) : MW'(comp[c]);
    end
  end

  always_comb begin
    sq_nxt[0]      = '0;
    sq_nxt[0].vld  = sum_vld_r;
    sq_nxt[0].zero = (s_r == '0);
    sq_nxt[0].neg  = sum_neg_r;
    sq_nxt[0].mag  = sum_mag_r;
    sq_nxt[0].rad  = {s_r, 16'b0};
    for (int j = 0; j < K; j++) begin
      sq_nxt[j+1]     = sq_r[j];
      rem_sh[j]       = {sq_r[j].rem[K-1:0], sq_r[j].rad[RW-1:RW-2]};
      trial[j]        = {sq_r[j].root, 2'b01};
      sq_nxt[j+1].rad = {sq_r[j].rad[RW-3:0], 2'b00};
      if (rem_sh[j] >= trial[j]) begin
        sq_nxt[j+1].rem  = rem_sh[j] - trial[j];
        sq_nxt[j+1].root = {sq_r[j].root[K-2:0], 1'b1};
      end else begin
        sq_nxt[j+1].rem  = rem_sh[j];
        sq_nxt[j+1].root = {sq_r[j].root[K-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    dv_nxt[0]      = '0;
    dv_nxt[0].vld  = sq_r[K].vld;
    dv_nxt[0].zero = sq_r[K].zero;
    dv_nxt[0].neg  = sq_r[K].neg;
    dv_nxt[0].dvs  = sq_r[K].root;
    for (int c = 0; c < 3; c++) begin
      dv_nxt[0].rem[c] = DW'({sq_r[K].mag[c], 22'b0}) + DW'(sq_r[K].root >> 1);
    end
    for (int i = 0; i < QW; i++) begin
      dv_nxt[i+1] = dv_r[i];
      for (int c = 0; c < 3; c++) begin
        dshift[i][c] = DW'(dv_r[i].dvs) << (QW - 1 - i);
        if (dv_r[i].rem[c] >= dshift[i][c]) begin
          dv_nxt[i+1].rem[c] = dv_r[i].rem[c] - dshift[i][c];
          dv_nxt[i+1].q[c]   = {dv_r[i].q[c][QW-2:0], 1'b1};
        end else begin
          dv_nxt[i+1].q[c]   = {dv_r[i].q[c][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qc[c] = (dv_r[QW].q[c] > QW'(UNIT)) ? QW'(UNIT) : dv_r[QW].q[c];
      if (dv_r[QW].zero) begin
        out_c_nxt[c] = '0;
      end else if (dv_r[QW].neg[c]) begin
        out_c_nxt[c] = -$signed(16'(qc[c]));
      end else begin
        out_c_nxt[c] = $signed(16'(qc[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      sqr_vld_r <= 1'b0;
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      for (int j = 0; j <= K; j++) sq_r[j] <= '0;
      for (int i = 0; i <= QW; i++) dv_r[i] <= '0;
    end else begin
      in_vld_r  <= in_vld;
      sqr_vld_r <= in_vld_r;
      sum_vld_r <= sqr_vld_r;
      out_vld_r <= dv_r[QW].vld;
      for (int j = 0; j <= K; j++) sq_r[j] <= sq_nxt[j];
      for (int i = 0; i <= QW; i++) dv_r[i] <= dv_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    in_neg_r  <= {in_z[CW-1], in_y[CW-1], in_x[CW-1]};
    in_mag_r  <= in_mag_nxt;
    sqr_neg_r <= in_neg_r;
    sqr_mag_r <= in_mag_r;
    for (int c = 0; c < 3; c++) sqr_r[c] <= in_mag_r[c] * in_mag_r[c];
    sum_neg_r <= sqr_neg_r;
    sum_mag_r <= sqr_mag_r;
    s_r       <= SW'(sqr_r[0]) + SW'(sqr_r[1]) + SW'(sqr_r[2]);
    for (int c = 0; c < 3; c++) out_c_r[c] <= out_c_nxt[c];
  end

  assign out_vld = out_vld_r;
  assign out_x   = out_c_r[0];
  assign out_y   = out_c_r[1];
  assign out_z   = out_c_r[2];

endmodule

[rtl/heightfield_vertex_normal_top.sv]
// Heightfield vertex normal: top level, edge vectors, cross products and sum.
// Depends on hvn_pkg, hvn_norm and heightfield_vertex_normal_top_assert.svh.
//
// Takes one neighbourhood word every cycle; busy is always low. Each word gives
// exactly one result word, out_strobe high for one cycle, once the word has passed
// through the edge and product stages, the quad normalise, a sum stage and the final
// normalise. Latency is set by the two normalise pipelines, whose square root
// resolves one root bit per stage and whose divide resolves one quotient bit per
// stage. Results cannot be held off.
module heightfield_vertex_normal_top import hvn_pkg::*; #(
  parameter int GRID_WIDTH    = 1024,
  parameter int COLUMN_HEIGHT = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hvn_in_t  in_data,
  output logic     out_strobe,
  output hvn_out_t out_data
);

  localparam int NL1 = hvn_norm_lat(CROSS_W);
  localparam int NL2 = hvn_norm_lat(SUM_W);
  localparam int LAT = 4 + NL1 + NL2;

  logic                     in_fire;
  logic                     vld_a_r, vld_b_r, sum_vld_r;
  hvn_vec_t                 va_r [4], vb_r [4];
  hvn_vec_t                 va_nxt [4], vb_nxt [4];
  logic signed [PROD_W-1:0] prod_r [4][6];
  logic signed [CROSS_W-1:0] cr_x [4], cr_y [4], cr_z [4];
  logic [3:0]               n1_vld;
  logic signed [15:0]       n1_x [4], n1_y [4], n1_z [4];
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0]  sum_x_nxt, sum_y_nxt, sum_z_nxt;

  logic signed [VEC_W-1:0] cx, cz, xl, xr, zu, zd;
  logic signed [VEC_W-1:0] hul, hml, hll, hmr, hlr, hc, hcu, hcl;
  logic [16:0]             xp1, zp1, xr_w, zd_w;

  function automatic logic signed [VEC_W-1:0] hsat(input logic [7:0] h);
    logic [16:0] hw;
    hw = (17'(h) > 17'(COLUMN_HEIGHT - 1)) ? 17'(COLUMN_HEIGHT - 1) : 17'(h);
    return $signed({{(VEC_W-8){1'b0}}, hw[7:0]});
  endfunction

  function automatic hvn_vec_t vsub(
    input logic signed [VEC_W-1:0] ax, input logic signed [VEC_W-1:0] ay,
    input logic signed [VEC_W-1:0] az, input logic signed [VEC_W-1:0] bx,
    input logic signed [VEC_W-1:0] by, input logic signed [VEC_W-1:0] bz);
    hvn_vec_t r;
    r.x = ax - bx;
    r.y = ay - by;
    r.z = az - bz;
    return r;
  endfunction

  assign in_fire = start && !busy;
  assign busy    = 1'b0;

  always_comb begin
    cx   = $signed({{(VEC_W-10){1'b0}}, in_data.grid_x});
    cz   = $signed({{(VEC_W-10){1'b0}}, in_data.grid_z});
    xl   = (in_data.grid_x != '0) ? cx - VEC_W'(1) : '0;
    zu   = (in_data.grid_z != '0) ? cz - VEC_W'(1) : '0;
    xp1  = 17'(in_data.grid_x) + 17'd1;
    zp1  = 17'(in_data.grid_z) + 17'd1;
    xr_w = (xp1 >= 17'(GRID_WIDTH)) ? 17'(GRID_WIDTH - 1) : xp1;
    zd_w = (zp1 >= 17'(GRID_WIDTH)) ? 17'(GRID_WIDTH - 1) : zp1;
    xr   = $signed({1'b0, xr_w[10:0]});
    zd   = $signed({1'b0, zd_w[10:0]});
    hul  = hsat(in_data.height_up_left);
    hml  = hsat(in_data.height_mid_left);
    hll  = hsat(in_data.height_low_left);
    hmr  = hsat(in_data.height_mid_right);
    hlr  = hsat(in_data.height_low_right);
    hc   = hsat(in_data.height_centre);
    hcu  = hsat(in_data.height_centre_up);
    hcl  = hsat(in_data.height_centre_low);
    // quads: ul-ml-c, ml-ll-cl, cu-c-mr, c-cl-lr
    va_nxt[0] = vsub(xl, hul, zu, xl, hml, cz);
    vb_nxt[0] = vsub(xl, hul, zu, cx, hc, cz);
    va_nxt[1] = vsub(xl, hml, cz, xl, hll, zd);
    vb_nxt[1] = vsub(xl, hml, cz, cx, hcl, zd);
    va_nxt[2] = vsub(cx, hcu, zu, cx, hc, cz);
    vb_nxt[2] = vsub(cx, hcu, zu, xr, hmr, cz);
    va_nxt[3] = vsub(cx, hc, cz, cx, hcl, zd);
    vb_nxt[3] = vsub(cx, hc, cz, xr, hlr, zd);
  end

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      cr_x[q] = CROSS_W'(prod_r[q][0]) - CROSS_W'(prod_r[q][1]);
      cr_y[q] = CROSS_W'(prod_r[q][2]) - CROSS_W'(prod_r[q][3]);
      cr_z[q] = CROSS_W'(prod_r[q][4]) - CROSS_W'(prod_r[q][5]);
    end
    sum_x_nxt = SUM_W'(n1_x[0]) + SUM_W'(n1_x[1]) + SUM_W'(n1_x[2]) + SUM_W'(n1_x[3]);
    sum_y_nxt = SUM_W'(n1_y[0]) + SUM_W'(n1_y[1]) + SUM_W'(n1_y[2]) + SUM_W'(n1_y[3]);
    sum_z_nxt = SUM_W'(n1_z[0]) + SUM_W'(n1_z[1]) + SUM_W'(n1_z[2]) + SUM_W'(n1_z[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      vld_a_r   <= in_fire;
      vld_b_r   <= vld_a_r;
      sum_vld_r <= n1_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < 4; q++) begin
      va_r[q]      <= va_nxt[q];
      vb_r[q]      <= vb_nxt[q];
      prod_r[q][0] <= va_r[q].y * vb_r[q].z;
      prod_r[q][1] <= va_r[q].z * vb_r[q].y;
      prod_r[q][2] <= va_r[q].z * vb_r[q].x;
      prod_r[q][3] <= va_r[q].x * vb_r[q].z;
      prod_r[q][4] <= va_r[q].x * vb_r[q].y;
      prod_r[q][5] <= va_r[q].y * vb_r[q].x;
    end
    sum_x_r <= sum_x_nxt;
    sum_y_r <= sum_y_nxt;
    sum_z_r <= sum_z_nxt;
  end

  for (genvar g = 0; g < 4; g++) begin : g_quad
    hvn_norm #(.CW(CROSS_W)) u_norm (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld_b_r),
      .in_x    (cr_x[g]),
      .in_y    (cr_y[g]),
      .in_z    (cr_z[g]),
      .out_vld (n1_vld[g]),
      .out_x   (n1_x[g]),
      .out_y   (n1_y[g]),
      .out_z   (n1_z[g])
    );
  end

  hvn_norm #(.CW(SUM_W)) u_norm_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sum_vld_r),
    .in_x    (sum_x_r),
    .in_y    (sum_y_r),
    .in_z    (sum_z_r),
    .out_vld (out_strobe),
    .out_x   (out_data.normal_x),
    .out_y   (out_data.normal_y),
    .out_z   (out_data.normal_z)
  );

`include "heightfield_vertex_normal_top_assert.svh"

  `HVN_ASSERT_NXT(a_accept_enters, in_fire, vld_a_r)
  `HVN_ASSERT_IMP(a_quads_aligned, n1_vld != 4'b0000, n1_vld == 4'b1111)
  `HVN_ASSERT_IMP(a_out_latency, out_strobe, $past(in_fire, LAT + 1))
  `HVN_ASSERT_IMP(a_out_range, out_strobe,
    out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
    out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384 &&
    out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384)

endmodule
